// File: src/assert_macros.svh
// Assertion macros shared by the waypoint table RTL.
// Depends on nothing; expects signals clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check that a condition at one edge is followed by an expectation at the next.
`define ASSERT_NEXT(label, cond, outcome, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (outcome)) \
    else $error(msg);

`endif

// File: src/wte_pkg.sv
// Shared types and constants of the waypoint table engine.
// Used by wte_cell, wte_chain and waypoint_table_engine; depends on nothing.
package wte_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam int ACT_W   = 3;
  localparam int ID_W    = 16;
  localparam int LAT_W   = 31;
  localparam int LON_W   = 32;
  localparam int ALT_W   = 16;
  localparam int KIND_W  = 2;
  localparam int RAD_W   = 17;
  localparam int RIDX_W  = 4;
  localparam int TOTAL_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_UPDATE = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_CLEAR  = 3'd4,
    ACT_READ   = 3'd5
  } action_t;

  typedef struct packed {
    logic        [ID_W-1:0]   id;
    logic signed [LAT_W-1:0]  latitude;
    logic signed [LON_W-1:0]  longitude;
    logic signed [ALT_W-1:0]  altitude;
    logic        [KIND_W-1:0] kind;
    logic signed [RAD_W-1:0]  radius;
  } record_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic    flag_en;
    logic    resolve_en;
    logic    apply_en;
    action_t action;
    logic    ok;
  } cell_ctrl_t;

  // Summary of a search, reduced over the row.
  typedef struct packed {
    logic hit_any;
    logic adj_any;
    logic last_eq;
  } search_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESOLVE,
    ST_APPLY
  } state_t;

endpackage

// File: src/wte_cell.sv
// One table position: holds a record, compares it with the search keys and
// shifts to or from its neighbours. Depends on wte_pkg.
module wte_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  wte_pkg::cell_ctrl_t       ctrl,
  input  logic [wte_pkg::ID_W-1:0]  key_a,
  input  logic [wte_pkg::ID_W-1:0]  key_b,
  input  wte_pkg::record_t          new_rec,
  input  wte_pkg::record_t          lower_rec,
  input  wte_pkg::record_t          upper_rec,
  input  logic                      in_table,
  input  logic                      lower_in_table,
  input  logic                      upper_in_table,
  input  logic                      seen_a_in,
  input  logic                      seen_b_in,
  input  logic                      first_b_lower,
  output logic                      seen_a_out,
  output logic                      seen_b_out,
  output logic                      first_b_out,
  output wte_pkg::record_t          rec,
  output logic                      hit,
  output logic                      adj,
  output logic                      last_eq
);
  import wte_pkg::*;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_FROM_LOWER,
    OP_FROM_UPPER
  } cell_op_t;

  logic     match_a;
  logic     match_b;
  logic     after;
  logic     first_a;
  logic     first_b;
  logic     is_last;
  logic     is_tail;
  cell_op_t op;
  record_t  rec_next;

  assign is_last     = in_table & ~upper_in_table;
  assign is_tail     = ~in_table & lower_in_table;
  assign seen_a_out  = seen_a_in | match_a;
  assign seen_b_out  = seen_b_in | match_b;
  assign first_a     = match_a & ~seen_a_in;
  assign first_b     = match_b & ~seen_b_in;
  assign first_b_out = first_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_a <= 1'b0;
      match_b <= 1'b0;
      last_eq <= 1'b0;
      hit     <= 1'b0;
      after   <= 1'b0;
      adj     <= 1'b0;
    end else begin
      if (ctrl.flag_en) begin
        match_a <= in_table && (rec.id == key_a);
        match_b <= in_table && (rec.id == key_b);
        last_eq <= is_last && (rec.latitude == new_rec.latitude) &&
                   (rec.longitude == new_rec.longitude);
      end
      if (ctrl.resolve_en) begin
        hit   <= first_a;
        after <= seen_a_in;
        adj   <= first_a & first_b_lower;
      end
    end
  end

  always_comb begin
    op = OP_HOLD;
    if (ctrl.apply_en && ctrl.ok) begin
      unique case (ctrl.action)
        ACT_APPEND: begin
          if (is_tail) op = OP_LOAD;
        end
        ACT_INSERT: begin
          if (hit) op = OP_LOAD;
          else if (after) op = OP_FROM_LOWER;
        end
        ACT_UPDATE: begin
          if (hit) op = OP_LOAD;
        end
        ACT_DELETE: begin
          if (hit || after) op = OP_FROM_UPPER;
        end
        default: op = OP_HOLD;
      endcase
    end
  end

  always_comb begin
    unique case (op)
      OP_LOAD:       rec_next = new_rec;
      OP_FROM_LOWER: rec_next = lower_rec;
      OP_FROM_UPPER: rec_next = upper_rec;
      default:       rec_next = rec;
    endcase
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

// File: src/wte_chain.sv
// Row of table cells with the neighbour links, search reduction and read select.
// Depends on wte_pkg, wte_cell and assert_macros.svh.
`include "assert_macros.svh"

module wte_chain #(
  parameter int  TABLE_DEPTH = wte_pkg::TABLE_DEPTH_DEF,
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  wte_pkg::cell_ctrl_t         ctrl,
  input  logic [wte_pkg::ID_W-1:0]    key_a,
  input  logic [wte_pkg::ID_W-1:0]    key_b,
  input  wte_pkg::record_t            new_rec,
  input  logic [CNT_W-1:0]            count,
  input  logic [wte_pkg::RIDX_W-1:0]  read_index,
  output wte_pkg::record_t            rd_rec,
  output wte_pkg::search_t            found
);
  import wte_pkg::*;

  localparam int RD_CELLS = (TABLE_DEPTH < (2 ** RIDX_W)) ? TABLE_DEPTH : (2 ** RIDX_W);

  record_t                recs       [TABLE_DEPTH];
  record_t                lower_recs [TABLE_DEPTH];
  record_t                upper_recs [TABLE_DEPTH];
  logic [TABLE_DEPTH+1:0] tbl;
  logic [TABLE_DEPTH:0]   seen_a;
  logic [TABLE_DEPTH:0]   seen_b;
  logic [TABLE_DEPTH:0]   first_b;
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [TABLE_DEPTH-1:0] adj_vec;
  logic [TABLE_DEPTH-1:0] eq_vec;

  // Position -1 counts as occupied, position TABLE_DEPTH as empty.
  assign tbl[0]               = 1'b1;
  assign tbl[TABLE_DEPTH+1]   = 1'b0;
  assign seen_a[0]            = 1'b0;
  assign seen_b[0]            = 1'b0;
  assign first_b[0]           = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign tbl[i+1] = (CNT_W'(i) < count);

    if (i == 0) begin : g_low_end
      assign lower_recs[i] = new_rec;
    end else begin : g_low_mid
      assign lower_recs[i] = recs[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_up_end
      assign upper_recs[i] = recs[i];
    end else begin : g_up_mid
      assign upper_recs[i] = recs[i+1];
    end

    wte_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .key_a          (key_a),
      .key_b          (key_b),
      .new_rec        (new_rec),
      .lower_rec      (lower_recs[i]),
      .upper_rec      (upper_recs[i]),
      .in_table       (tbl[i+1]),
      .lower_in_table (tbl[i]),
      .upper_in_table (tbl[i+2]),
      .seen_a_in      (seen_a[i]),
      .seen_b_in      (seen_b[i]),
      .first_b_lower  (first_b[i]),
      .seen_a_out     (seen_a[i+1]),
      .seen_b_out     (seen_b[i+1]),
      .first_b_out    (first_b[i+1]),
      .rec            (recs[i]),
      .hit            (hit_vec[i]),
      .adj            (adj_vec[i]),
      .last_eq        (eq_vec[i])
    );
  end

  assign found.hit_any = |hit_vec;
  assign found.adj_any = |adj_vec;
  assign found.last_eq = |eq_vec;

  // Only the first positions are reachable by the read index.
  always_comb begin
    rd_rec = '0;
    for (int i = 0; i < RD_CELLS; i++) begin
      if (RIDX_W'(i) == read_index) rd_rec = recs[i];
    end
  end

  `ASSERT_CLK(a_single_hit, $onehot0(hit_vec), "more than one cell claims the lookup")
  `ASSERT_CLK(a_single_tail, $onehot0(eq_vec), "more than one cell flagged as last entry")

endmodule

// File: src/waypoint_table_engine.sv
// Top level of the waypoint table engine: command sequencer, entry count and
// result register around the cell row. Depends on wte_pkg, wte_chain, assert_macros.svh.
//
//   transfer   handshake             payload
//   --------   -------------------   -----------------------------------------
//   command    cmd_valid, cmd_stall  action, new_*, target_id, previous_id,
//                                    next_id, read_index
//   result     rsp_valid, rsp_stall  status, entry_total, read_valid, read_*
//
// A command passes through the accepting idle state, a compare state in which
// every cell checks its id against the keys, a resolve state in which the
// first-match token ripples along the row, and an apply state that shifts or
// loads the cells and writes the result register.
// The apply state holds while the result register is full and stalled; one
// command is in flight at a time, so cmd_stall is high outside the idle state.
// Reset clears the entry count and the result valid; records keep whatever
// they held and are only ever read below the count.
`include "assert_macros.svh"

module waypoint_table_engine #(
  parameter int TABLE_DEPTH = wte_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  logic        [wte_pkg::ACT_W-1:0]  action,
  input  logic        [wte_pkg::ID_W-1:0]   new_id,
  input  logic signed [wte_pkg::LAT_W-1:0]  new_latitude,
  input  logic signed [wte_pkg::LON_W-1:0]  new_longitude,
  input  logic signed [wte_pkg::ALT_W-1:0]  new_altitude,
  input  logic        [wte_pkg::KIND_W-1:0] new_kind,
  input  logic signed [wte_pkg::RAD_W-1:0]  new_radius,
  input  logic        [wte_pkg::ID_W-1:0]   target_id,
  input  logic        [wte_pkg::ID_W-1:0]   previous_id,
  input  logic        [wte_pkg::ID_W-1:0]   next_id,
  input  logic        [wte_pkg::RIDX_W-1:0] read_index,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic                              status,
  output logic        [wte_pkg::TOTAL_W-1:0] entry_total,
  output logic                              read_valid,
  output logic        [wte_pkg::ID_W-1:0]   read_id,
  output logic signed [wte_pkg::LAT_W-1:0]  read_latitude,
  output logic signed [wte_pkg::LON_W-1:0]  read_longitude,
  output logic signed [wte_pkg::ALT_W-1:0]  read_altitude,
  output logic        [wte_pkg::KIND_W-1:0] read_kind,
  output logic signed [wte_pkg::RAD_W-1:0]  read_radius
);
  import wte_pkg::*;

  localparam int              CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int              CMP_W     = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  state_t            state;
  state_t            state_next;
  action_t           act;
  logic [ID_W-1:0]   key_a;
  logic [ID_W-1:0]   key_b;
  record_t           new_rec;
  logic [RIDX_W-1:0] ridx;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  cell_ctrl_t        ctrl;
  search_t           found;
  record_t           rd_rec;
  logic              cmd_take;
  logic              apply_go;
  logic              full;
  logic              rd_ok;
  logic              rd_hit;
  logic              ok;

  assign cmd_take = cmd_valid && !cmd_stall;
  assign apply_go = (state == ST_APPLY) && (!rsp_valid || !rsp_stall);
  assign full     = (count == DEPTH_CNT);
  assign rd_ok    = (CMP_W'(ridx) < CMP_W'(count));
  assign rd_hit   = (act == ACT_READ) && rd_ok;

  // Capture the command; insert searches for the following id, the rest for the target.
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      act     <= action_t'(action);
      key_a   <= (action == ACT_INSERT) ? next_id : target_id;
      key_b   <= previous_id;
      ridx    <= read_index;
      new_rec <= '{id: new_id, latitude: new_latitude, longitude: new_longitude,
                   altitude: new_altitude, kind: new_kind, radius: new_radius};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (cmd_take) state_next = ST_MATCH;
      ST_MATCH:   state_next = ST_RESOLVE;
      ST_RESOLVE: state_next = ST_APPLY;
      ST_APPLY:   if (apply_go) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall       = 1'b1;
    ctrl.flag_en    = 1'b0;
    ctrl.resolve_en = 1'b0;
    ctrl.apply_en   = 1'b0;
    ctrl.action     = act;
    ctrl.ok         = ok;
    unique case (state)
      ST_IDLE:    cmd_stall       = 1'b0;
      ST_MATCH:   ctrl.flag_en    = 1'b1;
      ST_RESOLVE: ctrl.resolve_en = 1'b1;
      ST_APPLY:   ctrl.apply_en   = apply_go;
      default:    cmd_stall       = 1'b1;
    endcase
  end

  // Outcome of the command and the count it leaves behind.
  always_comb begin
    ok         = 1'b0;
    count_next = count;
    case (act)
      ACT_APPEND: begin
        ok = !full && !found.last_eq;
        if (ok) count_next = count + 1'b1;
      end
      ACT_INSERT: begin
        ok = !full && found.adj_any;
        if (ok) count_next = count + 1'b1;
      end
      ACT_UPDATE: ok = found.hit_any;
      ACT_DELETE: begin
        ok = found.hit_any;
        if (ok) count_next = count - 1'b1;
      end
      ACT_CLEAR: begin
        ok         = 1'b1;
        count_next = '0;
      end
      ACT_READ: ok = rd_ok;
      default:  ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (apply_go) begin
      count <= count_next;
    end
  end

  // Result register: load on apply, drop once the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (apply_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      status         <= ~ok;
      entry_total    <= TOTAL_W'(count_next);
      read_valid     <= rd_hit;
      read_id        <= rd_hit ? rd_rec.id        : '0;
      read_latitude  <= rd_hit ? rd_rec.latitude  : '0;
      read_longitude <= rd_hit ? rd_rec.longitude : '0;
      read_altitude  <= rd_hit ? rd_rec.altitude  : '0;
      read_kind      <= rd_hit ? rd_rec.kind      : '0;
      read_radius    <= rd_hit ? rd_rec.radius    : '0;
    end
  end

  wte_chain #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .key_a      (key_a),
    .key_b      (key_b),
    .new_rec    (new_rec),
    .count      (count),
    .read_index (ridx),
    .rd_rec     (rd_rec),
    .found      (found)
  );

  `ASSERT_CLK(a_count_bound, count <= DEPTH_CNT, "entry count beyond table depth")
  `ASSERT_NEXT(a_take_starts, cmd_take, state == ST_MATCH, "accepted command not started")
  `ASSERT_NEXT(a_count_apply, state != ST_APPLY, $stable(count), "count moved outside apply")
  `ASSERT_CLK(a_rsp_from_apply, $rose(rsp_valid) |-> $past(state == ST_APPLY), "stray result")

endmodule

// File: tb/sv/waypoint_table_checker.sv
// Result checker for the waypoint table engine: mirrors the table from accepted
// commands and compares every result field in order. Depends on wte_pkg.
module waypoint_table_checker #(
  parameter int DEPTH = wte_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  input  logic                               cmd_stall,
  input  logic        [wte_pkg::ACT_W-1:0]   action,
  input  logic        [wte_pkg::ID_W-1:0]    new_id,
  input  logic signed [wte_pkg::LAT_W-1:0]   new_latitude,
  input  logic signed [wte_pkg::LON_W-1:0]   new_longitude,
  input  logic signed [wte_pkg::ALT_W-1:0]   new_altitude,
  input  logic        [wte_pkg::KIND_W-1:0]  new_kind,
  input  logic signed [wte_pkg::RAD_W-1:0]   new_radius,
  input  logic        [wte_pkg::ID_W-1:0]    target_id,
  input  logic        [wte_pkg::ID_W-1:0]    previous_id,
  input  logic        [wte_pkg::ID_W-1:0]    next_id,
  input  logic        [wte_pkg::RIDX_W-1:0]  read_index,
  input  logic                               rsp_valid,
  input  logic                               rsp_stall,
  input  logic                               status,
  input  logic        [wte_pkg::TOTAL_W-1:0] entry_total,
  input  logic                               read_valid,
  input  logic        [wte_pkg::ID_W-1:0]    read_id,
  input  logic signed [wte_pkg::LAT_W-1:0]   read_latitude,
  input  logic signed [wte_pkg::LON_W-1:0]   read_longitude,
  input  logic signed [wte_pkg::ALT_W-1:0]   read_altitude,
  input  logic        [wte_pkg::KIND_W-1:0]  read_kind,
  input  logic signed [wte_pkg::RAD_W-1:0]   read_radius,
  output int                                 mismatches,
  output int                                 awaiting,
  output int                                 replies_seen,
  output int                                 reads_returned,
  output int                                 refusals,
  output int                                 times_full
);
  import wte_pkg::*;

  typedef struct packed {
    logic               status;
    logic [TOTAL_W-1:0] total;
    logic               read_valid;
    record_t            rd;
  } table_reply_t;

  record_t      mirror [DEPTH];
  int           mirror_count;
  table_reply_t replies_due [$];

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("waypoint check: %s got 'h%0h, expected 'h%0h (result %0d)",
             what, got, want, replies_seen);
    mismatches++;
  endtask

  // Lowest position below the count that holds the key, or -1.
  function automatic int locate(input logic [ID_W-1:0] key);
    int pos = -1;
    for (int i = mirror_count - 1; i >= 0; i--)
      if (mirror[i].id == key) pos = i;
    return pos;
  endfunction

  function automatic table_reply_t apply_command(
    input logic [ACT_W-1:0]  act,
    input record_t           rec,
    input logic [ID_W-1:0]   tgt,
    input logic [ID_W-1:0]   prv,
    input logic [ID_W-1:0]   nxt,
    input logic [RIDX_W-1:0] ridx
  );
    table_reply_t r;
    int hit;
    int prv_pos;
    r = '0;
    r.status = 1'b1;
    case (act)
      ACT_APPEND: begin
        if (mirror_count < DEPTH) begin
          if (mirror_count == 0 ||
              mirror[mirror_count-1].latitude != rec.latitude ||
              mirror[mirror_count-1].longitude != rec.longitude) begin
            mirror[mirror_count] = rec;
            mirror_count++;
            r.status = 1'b0;
          end
        end
      end
      ACT_INSERT: begin
        if (mirror_count < DEPTH) begin
          hit = locate(nxt);
          prv_pos = locate(prv);
          if (hit > 0 && prv_pos >= 0 && prv_pos + 1 == hit) begin
            for (int i = mirror_count; i > hit; i--) mirror[i] = mirror[i-1];
            mirror[hit] = rec;
            mirror_count++;
            r.status = 1'b0;
          end
        end
      end
      ACT_UPDATE: begin
        hit = locate(tgt);
        if (hit >= 0) begin
          mirror[hit] = rec;
          r.status = 1'b0;
        end
      end
      ACT_DELETE: begin
        hit = locate(tgt);
        if (hit >= 0) begin
          for (int i = hit; i + 1 < mirror_count; i++) mirror[i] = mirror[i+1];
          mirror_count--;
          r.status = 1'b0;
        end
      end
      ACT_CLEAR: begin
        mirror_count = 0;
        r.status = 1'b0;
      end
      ACT_READ: begin
        if (ridx < mirror_count) begin
          r.status = 1'b0;
          r.read_valid = 1'b1;
          r.rd = mirror[ridx];
        end
      end
      default: ;
    endcase
    r.total = TOTAL_W'(mirror_count);
    if (r.status) refusals++;
    if (r.read_valid) reads_returned++;
    if (!r.status && mirror_count == DEPTH && (act == ACT_APPEND || act == ACT_INSERT))
      times_full++;
    return r;
  endfunction

  always @(posedge clk) begin
    table_reply_t want;
    if (rst) begin
      mirror_count = 0;
      replies_due.delete();
      awaiting <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        replies_seen++;
        if (replies_due.size() == 0) begin
          flag_mismatch("result with none pending, status/total", {status, entry_total}, 0);
        end else begin
          want = replies_due.pop_front();
          if (status !== want.status) flag_mismatch("status", status, want.status);
          if (entry_total !== want.total) flag_mismatch("entry_total", entry_total, want.total);
          if (read_valid !== want.read_valid)
            flag_mismatch("read_valid", read_valid, want.read_valid);
          if (read_id !== want.rd.id) flag_mismatch("read_id", read_id, want.rd.id);
          if (read_latitude !== want.rd.latitude)
            flag_mismatch("read_latitude", read_latitude, want.rd.latitude);
          if (read_longitude !== want.rd.longitude)
            flag_mismatch("read_longitude", read_longitude, want.rd.longitude);
          if (read_altitude !== want.rd.altitude)
            flag_mismatch("read_altitude", read_altitude, want.rd.altitude);
          if (read_kind !== want.rd.kind) flag_mismatch("read_kind", read_kind, want.rd.kind);
          if (read_radius !== want.rd.radius)
            flag_mismatch("read_radius", read_radius, want.rd.radius);
        end
      end
      if (cmd_valid && !cmd_stall)
        replies_due.push_back(apply_command(action,
          record_t'{new_id, new_latitude, new_longitude, new_altitude, new_kind, new_radius},
          target_id, previous_id, next_id, read_index));
      awaiting <= replies_due.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the waypoint table engine: clock, reset, command stimulus, result
// back-pressure and verdict. Depends on wte_pkg, waypoint_table_engine and waypoint_table_checker.
module tb;
  import wte_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int CALM_TAIL    = 200;  // final stretch with no idling on either side
  localparam int STALL_LIMIT  = 400;  // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES = 8;

  // Action codes beyond the defined set; the block must refuse them.
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      cmd_valid     = 1'b0;
  logic                      cmd_stall;
  logic        [ACT_W-1:0]   action        = '0;
  logic        [ID_W-1:0]    new_id        = '0;
  logic signed [LAT_W-1:0]   new_latitude  = '0;
  logic signed [LON_W-1:0]   new_longitude = '0;
  logic signed [ALT_W-1:0]   new_altitude  = '0;
  logic        [KIND_W-1:0]  new_kind      = '0;
  logic signed [RAD_W-1:0]   new_radius    = '0;
  logic        [ID_W-1:0]    target_id     = '0;
  logic        [ID_W-1:0]    previous_id   = '0;
  logic        [ID_W-1:0]    next_id       = '0;
  logic        [RIDX_W-1:0]  read_index    = '0;
  logic                      rsp_valid;
  logic                      rsp_stall     = 1'b0;
  logic                      status;
  logic        [TOTAL_W-1:0] entry_total;
  logic                      read_valid;
  logic        [ID_W-1:0]    read_id;
  logic signed [LAT_W-1:0]   read_latitude;
  logic signed [LON_W-1:0]   read_longitude;
  logic signed [ALT_W-1:0]   read_altitude;
  logic        [KIND_W-1:0]  read_kind;
  logic signed [RAD_W-1:0]   read_radius;

  int   mismatches;
  int   awaiting;
  int   replies_seen;
  int   reads_returned;
  int   refusals;
  int   times_full;
  int   commands_sent = 0;
  logic idle_on       = 1'b1;
  int   hold_left     = 0;
  int   quiet_cycles  = 0;

  always #6 clk = ~clk;

  waypoint_table_engine dut (
    .clk, .rst,
    .cmd_valid, .cmd_stall,
    .action, .new_id, .new_latitude, .new_longitude, .new_altitude, .new_kind,
    .new_radius, .target_id, .previous_id, .next_id, .read_index,
    .rsp_valid, .rsp_stall,
    .status, .entry_total, .read_valid, .read_id, .read_latitude, .read_longitude,
    .read_altitude, .read_kind, .read_radius
  );

  waypoint_table_checker table_check (
    .clk, .rst,
    .cmd_valid, .cmd_stall,
    .action, .new_id, .new_latitude, .new_longitude, .new_altitude, .new_kind,
    .new_radius, .target_id, .previous_id, .next_id, .read_index,
    .rsp_valid, .rsp_stall,
    .status, .entry_total, .read_valid, .read_id, .read_latitude, .read_longitude,
    .read_altitude, .read_kind, .read_radius,
    .mismatches, .awaiting, .replies_seen, .reads_returned, .refusals, .times_full
  );

  // Result back-pressure: hold stall for a burst while idling is on,
  // then drop it again. hold_left counts down the rest of the burst.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (rsp_stall) begin
      rsp_stall <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      rsp_stall <= 1'b1;
      hold_left <= $urandom_range(0, 6);
    end
  end

  // Watchdog: count cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic record_t make_rec(input int id, input int lat, input int lon,
                                       input int alt, input int kind, input int rad);
    record_t r;
    r.id        = ID_W'(id);
    r.latitude  = LAT_W'(lat);
    r.longitude = LON_W'(lon);
    r.altitude  = ALT_W'(alt);
    r.kind      = KIND_W'(kind);
    r.radius    = RAD_W'(rad);
    return r;
  endfunction

  // Present one command and hold it until the block takes it. While idling is on,
  // sometimes drop valid for a short burst first so gaps land on every phase of the block.
  task automatic issue(input logic [ACT_W-1:0] act, input record_t rec,
                       input logic [ID_W-1:0] tgt, input logic [ID_W-1:0] prv,
                       input logic [ID_W-1:0] nxt, input logic [RIDX_W-1:0] ridx);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    cmd_valid     <= 1'b1;
    action        <= act;
    new_id        <= rec.id;
    new_latitude  <= rec.latitude;
    new_longitude <= rec.longitude;
    new_altitude  <= rec.altitude;
    new_kind      <= rec.kind;
    new_radius    <= rec.radius;
    target_id     <= tgt;
    previous_id   <= prv;
    next_id       <= nxt;
    read_index    <= ridx;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    commands_sent++;
  endtask

  initial begin
    record_t          rec;
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0]  tgt;
    logic [ID_W-1:0]  prv;
    logic [ID_W-1:0]  nxt;
    int               pick;
    int               spot;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Start from an empty table and refuse what needs entries.
    issue(ACT_CLEAR, '0, 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_READ, '0, 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_DELETE, '0, 16'd5, 16'd0, 16'd0, 4'd0);
    // Low then high field values; id and altitude reach both ends of their fields.
    issue(ACT_APPEND, make_rec(0, -900000000, -1800000000, -32768, 0, -1),
          16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_APPEND, make_rec(65535, 900000000, 1800000000, 32767, 2, 65535),
          16'd0, 16'd0, 16'd0, 4'd0);
    // Same position as the last entry: refused even with a fresh id.
    issue(ACT_APPEND, make_rec(7, 900000000, 1800000000, 12, 1, 40),
          16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_APPEND, make_rec(3, 0, 0, 0, 1, 0), 16'd0, 16'd0, 16'd0, 4'd0);
    // Insert between the first two entries, then the failing forms: not adjacent,
    // an id that is missing, and the pair named in reverse order.
    issue(ACT_INSERT, make_rec(9, 123456789, -987654321, -300, 2, 250),
          16'd0, 16'd0, 16'hFFFF, 4'd0);
    issue(ACT_INSERT, make_rec(11, 5, 5, 5, 0, 5), 16'd0, 16'd0, 16'd3, 4'd0);
    issue(ACT_INSERT, make_rec(12, 6, 6, 6, 0, 6), 16'd0, 16'd0, 16'h1234, 4'd0);
    issue(ACT_INSERT, make_rec(13, 7, 7, 7, 0, 7), 16'd0, 16'hFFFF, 16'd0, 4'd0);
    issue(ACT_UPDATE, make_rec(40000, -1, -1, -1, 1, -1), 16'hFFFF, 16'd0, 16'd0, 4'd0);
    issue(ACT_UPDATE, make_rec(1, 1, 1, 1, 1, 1), 16'd4242, 16'd0, 16'd0, 4'd0);
    for (int i = 0; i < 5; i++) issue(ACT_READ, '0, 16'd0, 16'd0, 16'd0, RIDX_W'(i));
    issue(ACT_DELETE, '0, 16'd9, 16'd0, 16'd0, 4'd0);
    issue(ACT_DELETE, '0, 16'd4242, 16'd0, 16'd0, 4'd0);
    issue(ACT_SPARE_LO, '0, 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_SPARE_HI, '0, 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_READ, '0, 16'd0, 16'd0, 16'd0, 4'd15);
    // Duplicate id: the update must land on the lowest position.
    issue(ACT_APPEND, make_rec(3, 77, 77, 77, 2, 77), 16'd0, 16'd0, 16'd0, 4'd0);
    issue(ACT_UPDATE, make_rec(3, 88, 88, 88, 0, 88), 16'd3, 16'd0, 16'd0, 4'd0);
    issue(ACT_CLEAR, '0, 16'd0, 16'd0, 16'd0, 4'd0);

    // Random part. Keep ids in a small pool so lookups mostly hit, name consecutive ids
    // as the pair for most inserts, and reuse a few positions so repeated appends
    // collide. Clear rarely so the table fills up now and again.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0)
        idle_on <= (n < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      pick   = $urandom_range(0, 99);
      rec.id = ($urandom_range(0, 4) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 7));
      if ($urandom_range(0, 9) < 3) begin
        spot          = $urandom_range(0, 3);
        rec.latitude  = LAT_W'(spot * 250000000 - 400000000);
        rec.longitude = LON_W'(spot * 700000000 - 1000000000);
      end else begin
        rec.latitude  = LAT_W'(int'($urandom_range(0, 1800000000)) - 900000000);
        rec.longitude = LON_W'(longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000);
      end
      rec.altitude = ALT_W'($urandom);
      rec.kind     = ($urandom_range(0, 49) == 0) ? KIND_W'(3) : KIND_W'($urandom_range(0, 2));
      rec.radius   = RAD_W'(int'($urandom_range(0, 65536)) - 1);
      tgt = ($urandom_range(0, 7) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 7));
      prv = ID_W'($urandom_range(0, 7));
      nxt = ($urandom_range(0, 9) < 6) ? prv + 16'd1 : ID_W'($urandom_range(0, 7));
      if (pick < 31)      act = ACT_APPEND;
      else if (pick < 51) act = ACT_INSERT;
      else if (pick < 63) act = ACT_UPDATE;
      else if (pick < 75) act = ACT_DELETE;
      else if (pick < 96) act = ACT_READ;
      else if (pick < 97) act = ACT_CLEAR;
      else                act = $urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
      issue(act, rec, tgt, prv, nxt, RIDX_W'($urandom_range(0, 15)));
    end
    cmd_valid <= 1'b0;

    // Drain: let the checker register the last command, wait for every result,
    // then hold a few more cycles so a stray extra result is still caught.
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d commands and %0d results; %0d refused, %0d reads returned",
             commands_sent, replies_seen, refusals, reads_returned);
    $display("an entry, and the table was filled to capacity %0d times", times_full);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: waypoint_table_engine.f
+incdir+src
src/wte_pkg.sv
src/wte_cell.sv
src/wte_chain.sv
src/waypoint_table_engine.sv
tb/sv/waypoint_table_checker.sv
tb/sv/tb.sv
